[rtl/core/lshs_pkg.sv]
// shared types and constants for the limit switch homing sequencer
package lshs_pkg;

    localparam int POS_WIDTH       = 24;
    localparam int RETRACT_WIDTH   = 16;
    localparam int DRIVE_WIDTH     = 23;
    localparam int CFG_DATA_WIDTH  = 23;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int PHASE_WIDTH     = 4;

    typedef enum logic [PHASE_WIDTH-1:0] {
        PH_INIT          = 4'd0,
        PH_LEFT_FAST     = 4'd1,
        PH_LEFT_RETRACT  = 4'd2,
        PH_LEFT_SLOW     = 4'd3,
        PH_LEFT_SET      = 4'd4,
        PH_RIGHT_FAST    = 4'd5,
        PH_RIGHT_RETRACT = 4'd6,
        PH_RIGHT_SLOW    = 4'd7,
        PH_REPOS         = 4'd8,
        PH_DONE          = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        SPD_KEEP  = 2'd0,
        SPD_FAST  = 2'd1,
        SPD_SLOW  = 2'd2,
        SPD_ULTRA = 2'd3
    } speed_t;

    typedef enum logic [1:0] {
        MV_NONE     = 2'd0,
        MV_REL      = 2'd1,
        MV_REL_IDLE = 2'd2,
        MV_ABS      = 2'd3
    } move_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_SINGLE_CARRIAGE = 2'd0,
        CFG_RETRACT_STEPS   = 2'd1,
        CFG_DRIVE_STEPS     = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                     single_carriage;
        logic [RETRACT_WIDTH-1:0] retract_steps;
        logic [DRIVE_WIDTH-1:0]   drive_steps;
    } cfg_t;

    typedef struct packed {
        logic                 op;
        logic                 left_pressed;
        logic                 right_pressed;
        logic                 motion_done;
        logic [POS_WIDTH-1:0] current_position;
    } obs_t;

    typedef struct packed {
        phase_t               phase;
        logic                 stop_motor;
        speed_t               speed_select;
        move_t                move_kind;
        logic [POS_WIDTH-1:0] move_amount;
        logic                 zero_position;
        logic                 length_valid;
        logic [POS_WIDTH-1:0] track_length;
        logic                 done_res;
    } res_t;

endpackage

[rtl/core/lshs_cfg.sv]
// configuration registers of the homing sequencer
module lshs_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [lshs_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [lshs_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output lshs_pkg::cfg_t                        cfg
);
    import lshs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SINGLE_CARRIAGE: cfg_next.single_carriage = cfg_data[0];
                CFG_RETRACT_STEPS:   cfg_next.retract_steps = cfg_data[RETRACT_WIDTH-1:0];
                CFG_DRIVE_STEPS:     cfg_next.drive_steps = cfg_data[DRIVE_WIDTH-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.single_carriage <= 1'b1;
            cfg_reg.retract_steps   <= RETRACT_WIDTH'(200);
            cfg_reg.drive_steps     <= {DRIVE_WIDTH{1'b1}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/lshs_step.sv]
// phase transition and command decode for one item
module lshs_step (
    input  lshs_pkg::obs_t   obs,
    input  lshs_pkg::phase_t phase_cur,
    input  lshs_pkg::cfg_t   cfg,
    output lshs_pkg::phase_t phase_next,
    output lshs_pkg::res_t   res
);
    import lshs_pkg::*;

    logic [POS_WIDTH-1:0] retr_pos;
    logic [POS_WIDTH-1:0] retr_neg;
    logic [POS_WIDTH-1:0] drive_pos;
    logic [POS_WIDTH-1:0] drive_neg;
    logic [POS_WIDTH-1:0] pos_adj;
    logic [POS_WIDTH-1:0] pos_half;

    assign retr_pos  = {{(POS_WIDTH-RETRACT_WIDTH){1'b0}}, cfg.retract_steps};
    assign retr_neg  = -retr_pos;
    assign drive_pos = {{(POS_WIDTH-DRIVE_WIDTH){1'b0}}, cfg.drive_steps};
    assign drive_neg = -drive_pos;

    // halve toward zero: bias negatives by one before the arithmetic shift
    assign pos_adj  = obs.current_position
                    + {{(POS_WIDTH-1){1'b0}}, obs.current_position[POS_WIDTH-1]};
    assign pos_half = {pos_adj[POS_WIDTH-1], pos_adj[POS_WIDTH-1:1]};

    always_comb
    begin
        phase_next = phase_cur;
        if (obs.op)
        begin
            phase_next = PH_INIT;
        end
        else
        begin
            unique case (phase_cur)
                PH_INIT:          phase_next = PH_LEFT_FAST;
                PH_LEFT_FAST:     if (obs.left_pressed)  phase_next = PH_LEFT_RETRACT;
                PH_LEFT_RETRACT:  if (obs.motion_done)   phase_next = PH_LEFT_SLOW;
                PH_LEFT_SLOW:     if (obs.left_pressed)  phase_next = PH_LEFT_SET;
                PH_LEFT_SET:      if (obs.motion_done)   phase_next = PH_RIGHT_FAST;
                PH_RIGHT_FAST:    if (obs.right_pressed) phase_next = PH_RIGHT_RETRACT;
                PH_RIGHT_RETRACT: if (obs.motion_done)   phase_next = PH_RIGHT_SLOW;
                PH_RIGHT_SLOW:    if (obs.right_pressed) phase_next = PH_REPOS;
                PH_REPOS:         if (obs.motion_done)   phase_next = PH_DONE;
                default:          phase_next = PH_DONE;
            endcase
        end
    end

    always_comb
    begin
        res               = '0;
        res.phase         = phase_next;
        res.speed_select  = SPD_KEEP;
        res.move_kind     = MV_NONE;
        res.done_res      = (phase_next == PH_DONE);
        if (!obs.op)
        begin
            unique case (phase_cur)
                PH_INIT:
                begin
                    res.speed_select = SPD_FAST;
                end
                PH_LEFT_FAST:
                begin
                    if (obs.left_pressed)
                    begin
                        res.stop_motor  = 1'b1;
                        res.move_kind   = MV_REL;
                        res.move_amount = retr_pos;
                    end
                    else if (cfg.single_carriage)
                    begin
                        res.move_kind   = MV_REL_IDLE;
                        res.move_amount = drive_neg;
                    end
                end
                PH_RIGHT_FAST:
                begin
                    if (obs.right_pressed)
                    begin
                        res.stop_motor  = 1'b1;
                        res.move_kind   = MV_REL;
                        res.move_amount = retr_neg;
                    end
                    else if (cfg.single_carriage)
                    begin
                        res.move_kind   = MV_REL_IDLE;
                        res.move_amount = drive_pos;
                    end
                end
                PH_LEFT_RETRACT, PH_RIGHT_RETRACT:
                begin
                    if (obs.motion_done)
                        res.speed_select = SPD_SLOW;
                end
                PH_LEFT_SLOW:
                begin
                    if (obs.left_pressed)
                    begin
                        res.stop_motor = 1'b1;
                    end
                    else if (cfg.single_carriage)
                    begin
                        res.move_kind   = MV_REL_IDLE;
                        res.move_amount = drive_neg;
                    end
                end
                PH_LEFT_SET:
                begin
                    if (obs.motion_done)
                    begin
                        res.zero_position = 1'b1;
                        res.speed_select  = SPD_FAST;
                    end
                end
                PH_RIGHT_SLOW:
                begin
                    if (obs.right_pressed)
                    begin
                        res.stop_motor   = 1'b1;
                        res.length_valid = 1'b1;
                        res.track_length = obs.current_position;
                        res.speed_select = SPD_ULTRA;
                        res.move_kind    = MV_ABS;
                        res.move_amount  = pos_half;
                    end
                    else if (cfg.single_carriage)
                    begin
                        res.move_kind   = MV_REL_IDLE;
                        res.move_amount = drive_pos;
                    end
                end
                default:
                begin
                    res.stop_motor = 1'b0;
                end
            endcase
        end
    end

endmodule

[rtl/core/limit_switch_homing_sequencer.sv]
// top level of the limit switch homing sequencer
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | op, switch events, motion_done, position
//  out     | output    | out_valid / out_stall| phase and motor command fields
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; a taken item reaches the output
// through the input register, then the phase logic into the result register
// the phase register advances as an item moves from the input register to the result register
// rst_n clears the phase to init, empties both stages and loads the register defaults
// out_stall holds the result register; the input register still takes an item while it is empty
module limit_switch_homing_sequencer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic                                  left_pressed,
    input  logic                                  right_pressed,
    input  logic                                  motion_done,
    input  logic signed [lshs_pkg::POS_WIDTH-1:0] current_position,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [lshs_pkg::PHASE_WIDTH-1:0]      phase,
    output logic                                  stop_motor,
    output logic [1:0]                            speed_select,
    output logic [1:0]                            move_kind,
    output logic signed [lshs_pkg::POS_WIDTH-1:0] move_amount,
    output logic                                  zero_position,
    output logic                                  length_valid,
    output logic signed [lshs_pkg::POS_WIDTH-1:0] track_length,
    output logic                                  done_res,
    input  logic                                  cfg_we,
    input  logic [lshs_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [lshs_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import lshs_pkg::*;

    cfg_t   cfg;
    obs_t   obs_reg;
    logic   obs_valid_reg;
    res_t   res_reg;
    logic   res_valid_reg;
    phase_t phase_reg;
    phase_t phase_next;
    res_t   res_next;
    logic   res_adv;
    logic   obs_adv;
    logic   in_fire;
    logic   step_fire;

    lshs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lshs_step u_step (
        .obs        (obs_reg),
        .phase_cur  (phase_reg),
        .cfg        (cfg),
        .phase_next (phase_next),
        .res        (res_next)
    );

    assign res_adv   = !res_valid_reg || !out_stall;
    assign obs_adv   = !obs_valid_reg || res_adv;
    assign in_stall  = !obs_adv;
    assign in_fire   = in_valid && obs_adv;
    assign step_fire = obs_valid_reg && res_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obs_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_INIT;
        end
        else
        begin
            if (obs_adv)
                obs_valid_reg <= in_valid;
            if (res_adv)
                res_valid_reg <= obs_valid_reg;
            if (step_fire)
                phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            obs_reg.op               <= op;
            obs_reg.left_pressed     <= left_pressed;
            obs_reg.right_pressed    <= right_pressed;
            obs_reg.motion_done      <= motion_done;
            obs_reg.current_position <= current_position;
        end
        if (step_fire)
            res_reg <= res_next;
    end

    assign out_valid     = res_valid_reg;
    assign phase         = res_reg.phase;
    assign stop_motor    = res_reg.stop_motor;
    assign speed_select  = res_reg.speed_select;
    assign move_kind     = res_reg.move_kind;
    assign move_amount   = res_reg.move_amount;
    assign zero_position = res_reg.zero_position;
    assign length_valid  = res_reg.length_valid;
    assign track_length  = res_reg.track_length;
    assign done_res      = res_reg.done_res;

    // length capture only happens on the right slow hit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_valid |-> phase == PH_REPOS)
        else $error("length captured outside the reposition phase");

    // zeroing only on leaving the left position set phase
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_position |-> phase == PH_RIGHT_FAST)
        else $error("position zeroed outside the right fast seek");

    // a start item sends the sequencer back to init
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && obs_reg.op |=> phase_reg == PH_INIT)
        else $error("start item did not restart the sequence");

    // the held input item is neither lost nor overwritten while the output waits
    assert property (@(posedge clk) disable iff (!rst_n)
        obs_valid_reg && !res_adv |=> obs_valid_reg && $stable(obs_reg))
        else $error("input register changed while blocked");

    // phase register never leaves the defined range
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_DONE)
        else $error("phase register beyond done");

endmodule
